// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on i_clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: hw/rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// constants and types of the port scan detector
// ----------------------------------------------------------------------------
package psd_pkg;

    // default table sizes
    localparam int PSD_MAX_SOURCES = 64;
    localparam int PSD_MAX_PORTS   = 64;

    // fixed field widths
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int THR_W  = 7;
    localparam int UP_W   = 7;

    // threshold after reset
    localparam logic [THR_W-1:0] THR_RESET = 7'd10;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRC,
        ST_META,
        ST_LOAD,
        ST_PORT,
        ST_DONE
    } t_state;

endpackage

// File: hw/rtl/port_scan_detector.sv
// ----------------------------------------------------------------------------
// port_scan_detector
// unique destination port counting per source with one-time scan alert
// ----------------------------------------------------------------------------
// Usage: drive i_source_address and i_dest_port and raise start; the attempt
// is taken at a clock edge with start high and busy low. busy stays high
// while the attempt is processed. Exactly one result follows, shown for one
// cycle with o_result_strobe high: o_scan_alert, o_unique_ports and
// o_untracked. The receiver cannot stall; a result must be taken when shown.
// Processing is a linear walk, one comparator and one ram read per cycle,
// first over the source table and then over that source's port list.
// The threshold is written through i_cfg_we / i_cfg_wdata, by the user
// only while idle; the block itself does not enforce this.
// Reset (synchronous, active low) empties the source table and loads the
// threshold with 10; ram contents are not cleared, entries are only read
// after they are written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module port_scan_detector
    import psd_pkg::*;
#(
    parameter int MAX_SOURCES          = PSD_MAX_SOURCES,
    parameter int MAX_PORTS_PER_SOURCE = PSD_MAX_PORTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ADDR_W-1:0] i_source_address,
    input  logic [PORT_W-1:0] i_dest_port,
    input  logic              i_cfg_we,
    input  logic [THR_W-1:0]  i_cfg_wdata,
    output logic              o_result_strobe,
    output logic              o_scan_alert,
    output logic [UP_W-1:0]   o_unique_ports,
    output logic              o_untracked
);

    localparam int SLOT_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int PIDX_W = (MAX_PORTS_PER_SOURCE > 1) ? $clog2(MAX_PORTS_PER_SOURCE) : 1;
    localparam int ENT_W  = $clog2(MAX_SOURCES + 1);
    localparam int CNT_W  = $clog2(MAX_PORTS_PER_SOURCE + 1);
    localparam int IDX_W  = (ENT_W > CNT_W) ? ENT_W : CNT_W;
    localparam int CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam int META_W = CNT_W + 1;
    localparam int PA_W   = SLOT_W + PIDX_W;

    localparam logic [ENT_W-1:0] ENT_FULL = ENT_W'(MAX_SOURCES);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PORTS_PER_SOURCE);

    // control registers
    t_state            r_state, n_state;
    logic [THR_W-1:0]  r_threshold;
    logic [ENT_W-1:0]  r_entries, n_entries;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_rvld, n_rvld;
    logic [SLOT_W-1:0] r_ridx, n_ridx;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_alerted, n_alerted;
    logic              r_strobe, n_strobe;
    logic              r_alert, n_alert;
    logic [UP_W-1:0]   r_uports, n_uports;
    logic              r_untracked, n_untracked;

    // latched attempt
    logic [ADDR_W-1:0] r_addr;
    logic [PORT_W-1:0] r_port;

    // ram ports
    logic              src_we;
    logic [SLOT_W-1:0] src_waddr;
    logic [SLOT_W-1:0] src_raddr;
    logic [ADDR_W-1:0] src_rdata;
    logic              meta_we;
    logic [META_W-1:0] meta_wdata;
    logic [META_W-1:0] meta_rdata;
    logic              port_we;
    logic [PA_W-1:0]   port_waddr;
    logic [PA_W-1:0]   port_raddr;
    logic [PORT_W-1:0] port_rdata;

    logic              accept;
    logic              src_issue;
    logic              port_issue;
    logic              over_thr;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  thr_ext;

    assign accept     = start && !busy;
    assign busy       = (r_state != ST_IDLE);
    assign src_issue  = (r_idx < IDX_W'(r_entries));
    assign port_issue = (r_idx < IDX_W'(r_cnt));
    assign cnt_ext    = CMP_W'(r_cnt);
    assign thr_ext    = CMP_W'(r_threshold);
    assign over_thr   = (cnt_ext > thr_ext);

    // source addresses in insertion order
    psd_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_SOURCES), .AW(SLOT_W)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (src_waddr),
        .i_wdata (r_addr),
        .i_raddr (src_raddr),
        .o_rdata (src_rdata)
    );

    // per-source alerted flag and port count
    psd_ram #(.WIDTH(META_W), .DEPTH(MAX_SOURCES), .AW(SLOT_W)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_slot),
        .i_wdata (meta_wdata),
        .i_raddr (r_slot),
        .o_rdata (meta_rdata)
    );

    // per-source port lists, row = slot, column = list position
    psd_ram #(.WIDTH(PORT_W), .DEPTH(2 ** PA_W), .AW(PA_W)) u_port_ram (
        .i_clk   (i_clk),
        .i_we    (port_we),
        .i_waddr (port_waddr),
        .i_wdata (r_port),
        .i_raddr (port_raddr),
        .o_rdata (port_rdata)
    );

    // sequencer next state and ram controls
    always_comb begin
        n_state     = r_state;
        n_entries   = r_entries;
        n_idx       = r_idx;
        n_rvld      = r_rvld;
        n_ridx      = r_ridx;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        n_alerted   = r_alerted;
        n_strobe    = 1'b0;
        n_alert     = r_alert;
        n_uports    = r_uports;
        n_untracked = r_untracked;
        src_we      = 1'b0;
        src_waddr   = r_entries[SLOT_W-1:0];
        src_raddr   = r_idx[SLOT_W-1:0];
        meta_we     = 1'b0;
        meta_wdata  = {r_alerted, r_cnt};
        port_we     = 1'b0;
        port_waddr  = {r_slot, r_cnt[PIDX_W-1:0]};
        port_raddr  = {r_slot, r_idx[PIDX_W-1:0]};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_rvld  = 1'b0;
                    n_state = ST_SRC;
                end
            end

            // walk the source table, read one entry and compare the last
            ST_SRC: begin
                n_rvld = src_issue;
                n_ridx = r_idx[SLOT_W-1:0];
                if (src_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rvld && (src_rdata == r_addr)) begin
                    n_slot  = r_ridx;
                    n_rvld  = 1'b0;
                    n_state = ST_META;
                end else if (!r_rvld && !src_issue) begin
                    if (r_entries == ENT_FULL) begin
                        // new source, no room: report untracked
                        n_strobe    = 1'b1;
                        n_alert     = 1'b0;
                        n_uports    = '0;
                        n_untracked = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        // append the new source with an empty list
                        src_we    = 1'b1;
                        n_slot    = r_entries[SLOT_W-1:0];
                        n_entries = r_entries + 1'b1;
                        n_cnt     = '0;
                        n_alerted = 1'b0;
                        n_idx     = '0;
                        n_rvld    = 1'b0;
                        n_state   = ST_PORT;
                    end
                end
            end

            // meta read in flight
            ST_META: begin
                n_state = ST_LOAD;
            end

            ST_LOAD: begin
                n_cnt     = meta_rdata[CNT_W-1:0];
                n_alerted = meta_rdata[CNT_W];
                n_idx     = '0;
                n_rvld    = 1'b0;
                n_state   = ST_PORT;
            end

            // walk this source's port list
            ST_PORT: begin
                n_rvld = port_issue;
                if (port_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rvld && (port_rdata == r_port)) begin
                    n_rvld  = 1'b0;
                    n_state = ST_DONE;
                end else if (!r_rvld && !port_issue) begin
                    if (r_cnt < CNT_FULL) begin
                        port_we = 1'b1;
                        n_cnt   = r_cnt + 1'b1;
                    end
                    n_state = ST_DONE;
                end
            end

            // alert check, write back count and flag, present result
            ST_DONE: begin
                meta_we     = 1'b1;
                meta_wdata  = {r_alerted | over_thr, r_cnt};
                n_strobe    = 1'b1;
                n_alert     = over_thr && !r_alerted;
                n_uports    = cnt_ext[UP_W-1:0];
                n_untracked = 1'b0;
                n_state     = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_threshold <= THR_RESET;
            r_entries   <= '0;
            r_rvld      <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_entries <= n_entries;
            r_rvld    <= n_rvld;
            r_strobe  <= n_strobe;
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_ridx      <= n_ridx;
        r_slot      <= n_slot;
        r_cnt       <= n_cnt;
        r_alerted   <= n_alerted;
        r_alert     <= n_alert;
        r_uports    <= n_uports;
        r_untracked <= n_untracked;
        if (accept) begin
            r_addr <= i_source_address;
            r_port <= i_dest_port;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_scan_alert    = r_alert;
    assign o_unique_ports  = r_uports;
    assign o_untracked     = r_untracked;

    // checks
    `ASSERT_CLKD(a_accept_busy, accept |=> busy, "busy not raised after transfer")
    `ASSERT_NEVER(a_strobe_busy, o_result_strobe && busy, "result shown while busy")
    `ASSERT_CLKD(a_untracked_zero, (o_result_strobe && o_untracked) |-> (!o_scan_alert && (o_unique_ports == '0)), "untracked result not empty")
    `ASSERT_NEVER(a_entries_max, r_entries > ENT_FULL, "source count overflow")
    `ASSERT_CLKD(a_entries_step, (r_entries != $past(r_entries)) |-> ($past(r_state) == ST_SRC), "source count changed outside table walk")

endmodule

// File: hw/rtl/psd_ram.sv
// ----------------------------------------------------------------------------
// psd_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module psd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
